FILE: rtl/core/keyed_table_linear_interpolation_defines.svh
// Assertion macros shared by the keyed table blocks.
// Each macro expects clk and arst_n in scope.
`ifndef KEYED_TABLE_LINEAR_INTERPOLATION_DEFINES_SVH
`define KEYED_TABLE_LINEAR_INTERPOLATION_DEFINES_SVH

// Same-cycle implication.
`define KTI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KTI_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/kti_pkg.sv
`timescale 1ns / 1ps
package kti_pkg;
	localparam int GRID_POINTS_DEF = 32;
	localparam int CHANNELS_DEF    = 64;

	localparam int OPC_W      = 2;
	localparam int SLOT_W     = 6;
	localparam int GIDX_W     = 5;
	localparam int KEY_W      = 28;
	localparam int EN_W       = 32;
	localparam int XS_W       = 24;
	localparam int ST_W       = 2;
	localparam int NP_W       = 6;
	localparam int NC_W       = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int PROD_W     = XS_W + EN_W;
	localparam int DCNT_W     = $clog2(PROD_W);

	typedef enum logic [OPC_W-1:0] {
		OPC_GRID  = 2'd0,
		OPC_KEY   = 2'd1,
		OPC_VAL   = 2'd2,
		OPC_QUERY = 2'd3
	} opcode_t;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_TOP     = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
	localparam logic [ST_W-1:0] ST_BELOW   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_POINTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE, OP_CAPTURE, OP_DISPATCH, OP_KCMP, OP_TCMP, OP_TVAL, OP_BCMP,
		OP_GCMP, OP_Y1, OP_Y0, OP_MUL, OP_DIV, OP_FIN, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic nc_zero;
		logic key_hit;
		logic key_last;
		logic ge_top;
		logic below;
		logic g_found;
		logic div_last;
	} dp_sts_t;
endpackage

FILE: rtl/core/kti_req_if.sv
`timescale 1ns / 1ps
interface kti_req_if;
	import kti_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPC_W-1:0]    opcode;
	logic [SLOT_W-1:0]   slot;
	logic [GIDX_W-1:0]   grid_index;
	logic [KEY_W-1:0]    channel_key;
	logic [EN_W-1:0]     energy;
	logic [XS_W-1:0]     cross_section;
	modport source (output valid, opcode, slot, grid_index, channel_key, energy,
		cross_section, input ready);
	modport sink (input valid, opcode, slot, grid_index, channel_key, energy,
		cross_section, output ready);
endinterface

FILE: rtl/core/kti_rsp_if.sv
`timescale 1ns / 1ps
interface kti_rsp_if;
	import kti_pkg::*;
	logic            valid;
	logic            ready;
	logic [ST_W-1:0] status;
	logic [XS_W-1:0] value;
	modport source (output valid, status, value, input ready);
	modport sink (input valid, status, value, output ready);
endinterface

FILE: rtl/core/kti_cfg_if.sv
`timescale 1ns / 1ps
interface kti_cfg_if;
	import kti_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/kti_dp.sv
`timescale 1ns / 1ps
`include "keyed_table_linear_interpolation_defines.svh"
module kti_dp #(
	parameter int GRID_POINTS = kti_pkg::GRID_POINTS_DEF,
	parameter int CHANNELS    = kti_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kti_pkg::dp_cmd_t                cmd,
	output kti_pkg::dp_sts_t                sts,
	input  logic [kti_pkg::OPC_W-1:0]       req_opcode,
	input  logic [kti_pkg::SLOT_W-1:0]      req_slot,
	input  logic [kti_pkg::GIDX_W-1:0]      req_grid_index,
	input  logic [kti_pkg::KEY_W-1:0]       req_channel_key,
	input  logic [kti_pkg::EN_W-1:0]        req_energy,
	input  logic [kti_pkg::XS_W-1:0]        req_cross_section,
	input  logic                            cfg_we,
	input  logic [kti_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kti_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [kti_pkg::ST_W-1:0]        rsp_status,
	output logic [kti_pkg::XS_W-1:0]        rsp_value
);
	import kti_pkg::*;

	localparam int GW = $clog2(GRID_POINTS);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int VD = 2 ** (CW + GW);

	// configuration registers
	logic [NP_W-1:0] gpu_q;
	logic [NC_W-1:0] ncu_q;
	logic [NP_W-1:0] np;
	logic [NC_W-1:0] nc;
	logic [GW-1:0]   np_m1;

	// captured request
	logic [OPC_W-1:0]  opc_q;
	logic [SLOT_W-1:0] slot_q;
	logic [GIDX_W-1:0] gi_q;
	logic [KEY_W-1:0]  key_q;
	logic [EN_W-1:0]   e_q;
	logic [XS_W-1:0]   xs_q;

	// stores and their read registers
	logic [EN_W-1:0]  grid_mem [GRID_POINTS];
	logic [KEY_W-1:0] key_mem [CHANNELS];
	logic [XS_W-1:0]  val_mem [VD];
	logic [EN_W-1:0]  grid_rd_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [XS_W-1:0]  val_rd_q;

	// scan counters and arithmetic
	logic [CW-1:0]     k_q;
	logic [GW-1:0]     g_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic [EN_W-1:0]   x0_q, x1_q, span_q, rem_q;
	logic [XS_W-1:0]   y0_q, y1_q;
	logic              neg_q;
	logic [PROD_W-1:0] prod_q, prod_d;
	logic [XS_W-1:0]   dy;
	logic [EN_W-1:0]   dx;
	logic [EN_W:0]     trial;
	logic [ST_W-1:0]   res_status_q;
	logic [XS_W-1:0]   res_value_q;
	logic              grid_we, key_we, val_we;
	logic [CW+GW-1:0]  val_waddr, val_raddr;

	// clamp the configured counts
	always_comb begin
		if (gpu_q < NP_W'(2))
			np = NP_W'(2);
		else if (32'(gpu_q) > GRID_POINTS)
			np = NP_W'(GRID_POINTS);
		else
			np = gpu_q;
		if (32'(ncu_q) > CHANNELS)
			nc = NC_W'(CHANNELS);
		else
			nc = ncu_q;
		np_m1 = GW'(np - NP_W'(1));
	end

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpu_q <= NP_W'(32);
			ncu_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_POINTS: gpu_q <= cfg_data[NP_W-1:0];
				CFG_CHANNELS:    ncu_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode load writes
	assign grid_we = (cmd.op == OP_DISPATCH) && (opc_q == OPC_GRID) &&
		(32'(gi_q) < GRID_POINTS);
	assign key_we = (cmd.op == OP_DISPATCH) && (opc_q == OPC_KEY) &&
		(32'(slot_q) < CHANNELS);
	assign val_we = (cmd.op == OP_DISPATCH) && (opc_q == OPC_VAL) &&
		(32'(slot_q) < CHANNELS) && (32'(gi_q) < GRID_POINTS);
	assign val_waddr = {CW'(slot_q), GW'(gi_q)};
	assign val_raddr = {k_q, g_q};

	// write and read the stores
	always_ff @(posedge clk) begin
		if (grid_we)
			grid_mem[GW'(gi_q)] <= e_q;
		if (key_we)
			key_mem[CW'(slot_q)] <= key_q;
		if (val_we)
			val_mem[val_waddr] <= xs_q;
		grid_rd_q <= grid_mem[g_q];
		key_rd_q  <= key_mem[k_q];
		val_rd_q  <= val_mem[val_raddr];
	end

	// interpolation arithmetic
	assign dy     = (y1_q >= y0_q) ? (y1_q - y0_q) : (y0_q - y1_q);
	assign dx     = e_q - x0_q;
	assign prod_d = dy * dx;
	assign trial  = {rem_q, prod_q[PROD_W-1]};

	// advance scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			g_q       <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_DISPATCH: k_q <= '0;
				OP_KCMP: begin
					if (sts.key_hit)
						g_q <= np_m1;
					else if (!sts.key_last)
						k_q <= k_q + CW'(1);
				end
				OP_TCMP: if (!sts.ge_top) g_q <= '0;
				OP_BCMP: g_q <= GW'(1);
				OP_GCMP: if (!sts.g_found) g_q <= g_q + GW'(1);
				OP_Y1:   g_q <= g_q - GW'(1);
				OP_MUL:  div_cnt_q <= '0;
				OP_DIV:  div_cnt_q <= div_cnt_q + DCNT_W'(1);
				default: ;
			endcase
		end
	end

	// hold request, bracket and result data
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				opc_q  <= req_opcode;
				slot_q <= req_slot;
				gi_q   <= req_grid_index;
				key_q  <= req_channel_key;
				e_q    <= req_energy;
				xs_q   <= req_cross_section;
			end
			OP_DISPATCH: begin
				res_status_q <= (opc_q == OPC_QUERY) ? ST_MISSING : ST_OK;
				res_value_q  <= '0;
			end
			OP_TVAL: begin
				res_status_q <= ST_TOP;
				res_value_q  <= val_rd_q;
			end
			OP_BCMP: begin
				if (sts.below)
					res_status_q <= ST_BELOW;
				x0_q <= grid_rd_q;
			end
			OP_GCMP: begin
				if (sts.g_found)
					x1_q <= grid_rd_q;
				else
					x0_q <= grid_rd_q;
			end
			OP_Y1: y1_q <= val_rd_q;
			OP_Y0: y0_q <= val_rd_q;
			OP_MUL: begin
				prod_q <= prod_d;
				span_q <= x1_q - x0_q;
				neg_q  <= y1_q < y0_q;
				rem_q  <= '0;
			end
			OP_DIV: begin
				if (trial >= {1'b0, span_q}) begin
					rem_q  <= EN_W'(trial - {1'b0, span_q});
					prod_q <= {prod_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q  <= trial[EN_W-1:0];
					prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				end
			end
			OP_FIN: begin
				res_status_q <= ST_OK;
				res_value_q  <= neg_q ? (y0_q - prod_q[XS_W-1:0]) :
					(y0_q + prod_q[XS_W-1:0]);
			end
			OP_OUT: begin
				rsp_status <= res_status_q;
				rsp_value  <= res_value_q;
			end
			default: ;
		endcase
	end

	// report status to the controller
	always_comb begin
		sts.is_query = opc_q == OPC_QUERY;
		sts.nc_zero  = nc == '0;
		sts.key_hit  = key_rd_q == key_q;
		sts.key_last = (32'(k_q) + 1) >= 32'(nc);
		sts.ge_top   = e_q >= grid_rd_q;
		sts.below    = e_q < grid_rd_q;
		sts.g_found  = (grid_rd_q > e_q) || (g_q == np_m1);
		sts.div_last = div_cnt_q == DCNT_W'(PROD_W - 1);
	end

	`KTI_ASSERT_IMP(a_div_cnt_range, cmd.op == OP_DIV, 32'(div_cnt_q) < PROD_W, "divide overran")
	`KTI_ASSERT_IMP(a_key_range, 1'b1, 32'(k_q) < CHANNELS, "key scan left the table")
	`KTI_ASSERT_IMP(a_grid_range, 1'b1, 32'(g_q) < GRID_POINTS, "grid scan left the grid")
endmodule

FILE: rtl/core/kti_ctrl.sv
`timescale 1ns / 1ps
`include "keyed_table_linear_interpolation_defines.svh"
module kti_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output kti_pkg::dp_cmd_t cmd,
	input  kti_pkg::dp_sts_t sts
);
	import kti_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001, S_DISP = 18'h00002, S_KRD  = 18'h00004,
		S_KCMP = 18'h00008, S_TRD  = 18'h00010, S_TCMP = 18'h00020,
		S_TVAL = 18'h00040, S_BRD  = 18'h00080, S_BCMP = 18'h00100,
		S_GRD  = 18'h00200, S_GCMP = 18'h00400, S_Y1   = 18'h00800,
		S_Y0W  = 18'h01000, S_Y0   = 18'h02000, S_MUL  = 18'h04000,
		S_DIV  = 18'h08000, S_FIN  = 18'h10000, S_DONE = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// sequence one request
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.op  = OP_DISPATCH;
				state_d = (!sts.is_query || sts.nc_zero) ? S_DONE : S_KRD;
			end
			S_KRD: state_d = S_KCMP;
			S_KCMP: begin
				cmd.op = OP_KCMP;
				priority if (sts.key_hit)
					state_d = S_TRD;
				else if (sts.key_last)
					state_d = S_DONE;
				else
					state_d = S_KRD;
			end
			S_TRD: state_d = S_TCMP;
			S_TCMP: begin
				cmd.op  = OP_TCMP;
				state_d = sts.ge_top ? S_TVAL : S_BRD;
			end
			S_TVAL: begin
				cmd.op  = OP_TVAL;
				state_d = S_DONE;
			end
			S_BRD: state_d = S_BCMP;
			S_BCMP: begin
				cmd.op  = OP_BCMP;
				state_d = sts.below ? S_DONE : S_GRD;
			end
			S_GRD: state_d = S_GCMP;
			S_GCMP: begin
				cmd.op  = OP_GCMP;
				state_d = sts.g_found ? S_Y1 : S_GRD;
			end
			S_Y1: begin
				cmd.op  = OP_Y1;
				state_d = S_Y0W;
			end
			S_Y0W: state_d = S_Y0;
			S_Y0: begin
				cmd.op  = OP_Y0;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op  = OP_DIV;
				state_d = sts.div_last ? S_FIN : S_DIV;
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`KTI_ASSERT_NXT(a_accept_disp, in_valid && in_ready, state_q == S_DISP, "accept not dispatched")
	`KTI_ASSERT_NXT(a_done_hold, (state_q == S_DONE) && out_valid_q && !out_ready, state_q == S_DONE, "result overwrote a pending one")
	`KTI_ASSERT_NXT(a_div_fin, (state_q == S_DIV) && sts.div_last, state_q == S_FIN, "divide did not finish")
endmodule

FILE: rtl/core/keyed_table_linear_interpolation.sv
`timescale 1ns / 1ps
// A load is captured, written to its store at dispatch, then answered. A query
// compares k slots in turn over the single key port, with a read and a compare
// state each, scans i grid points likewise over the single grid port, then runs
// a 56-step bit-serial divide. One request at a time; reset clears the controller,
// configuration and scan counters; stores and data registers stay.
module keyed_table_linear_interpolation #(
	parameter int GRID_POINTS = kti_pkg::GRID_POINTS_DEF,
	parameter int CHANNELS    = kti_pkg::CHANNELS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kti_req_if.sink   req,
	kti_rsp_if.source rsp,
	kti_cfg_if.sink   cfg
);
	import kti_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	kti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	kti_dp #(
		.GRID_POINTS (GRID_POINTS),
		.CHANNELS    (CHANNELS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_opcode        (req.opcode),
		.req_slot          (req.slot),
		.req_grid_index    (req.grid_index),
		.req_channel_key   (req.channel_key),
		.req_energy        (req.energy),
		.req_cross_section (req.cross_section),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.rsp_status        (rsp.status),
		.rsp_value         (rsp.value)
	);
endmodule
